// ----- sv/aofb_pkg.sv -----
// -----------------------------------------------------------------------------
// AES-128 OFB stream cipher package
// Shared types, constants and AES byte functions.
// -----------------------------------------------------------------------------
`default_nettype none

package aofb_pkg;

    localparam int unsigned REG_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd3;

    // One classified beat passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } aofb_item_t;

    // Standard AES S-box
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One AES round on a 128-bit state (byte 0 in bits 127:120)
    function automatic logic [127:0] aes_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic       last);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            s[i] = SBOX[st[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = s[4*((c+r)%4)+r];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = t[i];
        return res ^ rk;
    endfunction

    // Next round key from the current one
    function automatic logic [127:0] next_key(input logic [127:0] k,
                                              input logic [7:0]   rcon);
        logic [31:0] w0, w1, w2, w3, t;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

// ----- sv/aofb_front.sv -----
// -----------------------------------------------------------------------------
// AES OFB front end
// Accepts input beats and holds them in a two-entry queue for the back end.
// -----------------------------------------------------------------------------
`default_nettype none

module aofb_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire aofb_pkg::aofb_item_t in_item,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output aofb_pkg::aofb_item_t    q_item
);
    import aofb_pkg::*;

    aofb_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");

endmodule

`default_nettype wire

// ----- sv/aofb_back.sv -----
// -----------------------------------------------------------------------------
// AES OFB back end
// Round-per-cycle AES keystream engine and output byte register.
// -----------------------------------------------------------------------------
`default_nettype none

module aofb_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [127:0]         key,
    input  wire logic [127:0]         iv,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire aofb_pkg::aofb_item_t q_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte
);
    import aofb_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} state_t;

    state_t       state_reg;
    logic [127:0] ks_reg;
    logic [127:0] rk_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   round_reg;
    logic [4:0]   pos_reg;
    logic         started_reg;
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic         need_iv, need_blk, out_free;
    logic [127:0] rk_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign need_iv   = q_item.restart || !started_reg;
    assign need_blk  = pos_reg[4];
    assign q_ready   = (state_reg == ST_IDLE) && q_valid && !need_iv && !need_blk
                       && out_free;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign rk_next   = next_key(rk_reg, rcon_reg);

    // Sequencer: one AES round per cycle, then emit bytes from the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 5'd16;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            round_reg     <= 4'd0;
            rcon_reg      <= 8'h01;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && (need_iv || need_blk))
                    begin
                        state_reg <= ST_LOAD;
                        if (need_iv)
                        begin
                            ks_reg      <= iv ^ key;
                            started_reg <= 1'b1;
                        end
                        else
                            ks_reg <= ks_reg ^ key;
                        rk_reg    <= key;
                        rcon_reg  <= 8'h01;
                        round_reg <= 4'd1;
                    end
                    else if (q_ready)
                    begin
                        out_byte_reg  <= q_item.data_byte ^
                                         ks_reg[127 - 8*pos_reg[3:0] -: 8];
                        out_valid_reg <= 1'b1;
                        pos_reg       <= pos_reg + 5'd1;
                    end
                end
                ST_LOAD:
                begin
                    rk_reg    <= rk_next;
                    rcon_reg  <= xt(rcon_reg);
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    ks_reg   <= aes_round(ks_reg, rk_reg, round_reg == 4'd10);
                    rk_reg   <= rk_next;
                    rcon_reg <= xt(rcon_reg);
                    if (round_reg == 4'd10)
                    begin
                        state_reg <= ST_IDLE;
                        pos_reg   <= 5'd0;
                        // the top level masks the restart so the beat is served next
                    end
                    round_reg <= round_reg + 4'd1;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Accept only while idle, round count in range, no byte served from a spent block
    assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> (state_reg == ST_IDLE)) else $error("accept while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (round_reg >= 4'd1 && round_reg <= 4'd10))
        else $error("round count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> !pos_reg[4]) else $error("byte served from spent block");

endmodule

`default_nettype wire

// ----- sv/aes128_ofb_stream_cipher.sv -----
// -----------------------------------------------------------------------------
// AES-128 OFB byte-stream cipher
// XORs each byte with an AES-128 output-feedback keystream.
// -----------------------------------------------------------------------------
// channel   ports                          contents
// s_axis    s_axis_tvalid/tready/tdata/tuser  tdata: data_byte; tuser: restart
// m_axis    m_axis_tvalid/tready/tdata       tdata: out_byte
// cfg       cfg_we/cfg_index/cfg_data        key_high, key_low, iv_high, iv_low
//
// A byte is served directly when its keystream block is ready; a new block needs
// a pass of the round-per-cycle AES engine (key load, ten rounds, round key
// schedule computed alongside). Reset clears all control state; keystream
// empty, so the first byte starts from the IV. Either side may stall freely.
// -----------------------------------------------------------------------------
`default_nettype none

module aes128_ofb_stream_cipher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] restart
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import aofb_pkg::*;

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    aofb_item_t  in_item, q_item, q_item_mod;
    logic        q_valid, q_ready;
    logic        rst_done_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.restart   = s_axis_tuser;

    aofb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // A restart is honoured once: after its block is made the beat is plain.
    logic restart_done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restart_done_reg <= 1'b0;
        else if (q_valid && q_ready)
            restart_done_reg <= 1'b0;
        else if (q_valid && q_item.restart && rst_done_reg)
            restart_done_reg <= 1'b1;
    end

    // Registered mark that the head beat is waiting without being taken (block work or output stall)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rst_done_reg <= 1'b0;
        else
            rst_done_reg <= q_valid && !(q_valid && q_ready);
    end

    assign q_item_mod.data_byte = q_item.data_byte;
    assign q_item_mod.restart   = q_item.restart && !restart_done_reg && !rst_done_reg;

    aofb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .iv        ({iv_high_reg, iv_low_reg}),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item_mod),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- bench/aes128_ofb_stream_cipher_tb.sv -----
// -----------------------------------------------------------------------------
// AES-128 OFB stream cipher testbench
// Drives byte beats with random gaps and stalls across several key/IV settings,
// predicts each output byte with a separate AES-128 OFB model (package S-box) and compares.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aes128_ofb_stream_cipher_tb;

    import aofb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 410;
    localparam int N_DIRECTED     = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0; // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] out_byte
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    always #6 clk = ~clk;

    aes128_ofb_stream_cipher i_dut (.*);

    // Predictor state
    logic [63:0]  mdl_key_hi, mdl_key_lo, mdl_iv_hi, mdl_iv_lo;
    logic [127:0] mdl_keystream;
    int           mdl_pos;
    bit           mdl_started;

    logic [7:0] expected_bytes [$];
    int         fail_count = 0;
    int         idle_cycles = 0;
    bit         sending_done = 1'b0;

    // Directed stimulus: {data, restart, check literal, literal value}
    typedef struct {
        logic [7:0] data;
        logic       restart;
        bit         has_lit;
        logic [7:0] lit;
    } stim_row_t;

    // With all-zero key and IV the first keystream block is
    // 66e94bd4ef8a2c3b884cfa59ca342b2e, so a zero byte reads off directly.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1, 8'h66}, '{8'h00, 1'b0, 1, 8'he9},
        '{8'hff, 1'b0, 1, 8'hb4}, '{8'h00, 1'b1, 1, 8'h66},
        '{8'hff, 1'b0, 0, 8'h00}, '{8'h55, 1'b0, 0, 8'h00},
        '{8'haa, 1'b0, 0, 8'h00}, '{8'h01, 1'b0, 0, 8'h00},
        '{8'h80, 1'b0, 0, 8'h00}, '{8'h00, 1'b0, 0, 8'h00},
        '{8'h00, 1'b0, 0, 8'h00}, '{8'h00, 1'b0, 0, 8'h00},
        '{8'h00, 1'b0, 0, 8'h00}, '{8'h00, 1'b0, 0, 8'h00},
        '{8'h00, 1'b0, 0, 8'h00}, '{8'h00, 1'b0, 1, 8'hca},
        '{8'h00, 1'b0, 0, 8'h00}, '{8'hff, 1'b0, 0, 8'h00},
        '{8'h00, 1'b1, 1, 8'h66}, '{8'h00, 1'b0, 1, 8'he9}
    };

    function automatic logic [7:0] gf_x2(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption of one block, round keys generated on the fly
    function automatic logic [127:0] aes128_encrypt(logic [127:0] blk, logic [127:0] key);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] rk;
        logic [31:0]  w [4];
        logic [31:0]  tmp;
        logic [7:0]   rcon;
        rk = key;
        rcon = 8'h01;
        for (int i = 0; i < 16; i++)
            st[i] = blk[127-8*i -: 8] ^ rk[127-8*i -: 8];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                w[c] = rk[127-32*c -: 32];
            tmp = {w[3][23:0], w[3][31:24]};
            tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]};
            w[0] = w[0] ^ tmp ^ {rcon, 24'h0};
            w[1] = w[1] ^ w[0];
            w[2] = w[2] ^ w[1];
            w[3] = w[3] ^ w[2];
            rk = {w[0], w[1], w[2], w[3]};
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[4*c+r] = SBOX[st[4*((c+r)%4)+r]];
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
                    sh[4*c]   = gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3;
                    sh[4*c+1] = a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3;
                    sh[4*c+2] = a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3;
                    sh[4*c+3] = gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = sh[i] ^ rk[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++)
            blk[127-8*i -: 8] = st[i];
        return blk;
    endfunction

    // Next cipher output byte; advances the keystream state
    function automatic logic [7:0] ofb_next_byte(logic [7:0] data, logic restart);
        logic [7:0] ks;
        if (restart || !mdl_started)
        begin
            mdl_keystream = aes128_encrypt({mdl_iv_hi, mdl_iv_lo}, {mdl_key_hi, mdl_key_lo});
            mdl_pos = 0;
            mdl_started = 1'b1;
        end
        else if (mdl_pos >= 16)
        begin
            mdl_keystream = aes128_encrypt(mdl_keystream, {mdl_key_hi, mdl_key_lo});
            mdl_pos = 0;
        end
        ks = mdl_keystream[127-8*mdl_pos -: 8];
        mdl_pos++;
        return data ^ ks;
    endfunction

    // Valid stays high into the next beat when no gap is drawn
    task automatic send_byte(logic [7:0] data, logic restart);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_bytes.push_back(ofb_next_byte(data, restart));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY_HIGH: mdl_key_hi = val;
            REG_KEY_LOW:  mdl_key_lo = val;
            REG_IV_HIGH:  mdl_iv_hi  = val;
            default:      mdl_iv_lo  = val;
        endcase
        @(posedge clk);
    endtask

    // Block is idle once all results are back plus a block time
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Output side: random stalls, compare each beat
    initial
    begin : receiver
        int stall;
        logic [7:0] exp_byte;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: unexpected beat, actual %02h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_byte = expected_bytes.pop_front();
                if (m_axis_tdata !== exp_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h", exp_byte, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || sending_done)
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("aes128_ofb_stream_cipher_tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0] phase_vals [4];
        int sent;
        int msg_len;
        mdl_key_hi = '0; mdl_key_lo = '0; mdl_iv_hi = '0; mdl_iv_lo = '0;
        mdl_pos = 16; mdl_started = 1'b0; mdl_keystream = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part against the reset key and IV
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].restart);
            if (directed_rows[i].has_lit && expected_bytes[$] !== directed_rows[i].lit)
            begin
                $error("out_byte: expected %02h, actual %02h (predictor)",
                       directed_rows[i].lit, expected_bytes[$]);
                fail_count++;
            end
        end
        wait_drained();

        // Phases: all ones, mixed, then random settings
        sent = 0;
        for (int ph = 0; sent < N_RANDOM; ph++)
        begin
            for (int r = 0; r < 4; r++)
                phase_vals[r] = (ph == 0) ? '1 : (ph == 1) ? {32'h0, 32'hffffffff} : rand64();
            write_reg(REG_KEY_HIGH, phase_vals[0]);
            write_reg(REG_KEY_LOW,  phase_vals[1]);
            write_reg(REG_IV_HIGH,  phase_vals[2]);
            write_reg(REG_IV_LOW,   phase_vals[3]);
            // Messages of mixed length, some beyond several blocks
            for (int m = 0; m < 4 && sent < N_RANDOM; m++)
            begin
                msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 60)
                                                      : $urandom_range(1, 20);
                for (int b = 0; b < msg_len; b++)
                begin
                    send_byte(8'($urandom_range(0, 255)),
                              (b == 0) ? 1'b1 : ($urandom_range(0, 40) == 0));
                    sent++;
                end
            end
            wait_drained();
            // Key change mid-message applies from the next block
            if (ph == 2)
            begin
                write_reg(REG_KEY_LOW, rand64());
                for (int b = 0; b < 20; b++)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    sent++;
                end
                wait_drained();
            end
        end

        sending_done = 1'b1;
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("aes128_ofb_stream_cipher_tb: PASS");
        else
            $display("aes128_ofb_stream_cipher_tb: FAIL");
        $finish;
    end

endmodule
